// ----- hw/rtl/kce_pkg.sv -----
package kce_pkg;

    // Store depth and the widths that follow from it.
    localparam int MAX_ELEMENTS = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = IDX_W + 1;
    localparam int K_W          = 5;
    localparam int VAL_W        = 8;
    localparam int CMP_W        = ((CNT_W > K_W) ? CNT_W : K_W) + 2;

    // Input operation codes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_NEXT = 1'b1;

    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [VAL_W-1:0] t_val;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;      // insert the request value into the sorted store
        logic restart;     // clear the started and done flags
        logic init_slots;  // first combination: slot j holds position j
        logic scan_start;  // cursor to the last slot of the combination
        logic cur_dec;     // move the scan cursor one slot left
        logic advance;     // bump the slot at the cursor and refill the rest
        logic set_done;    // the combinations have run out
        logic emit_elem;   // present the element at the cursor slot
        logic emit_exh;    // present an exhausted result
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic k_bad;       // no combination can be given now
        logic started;     // the first combination has been given
        logic can_adv;     // the slot at the cursor can still advance
        logic cur_zero;    // the cursor is at the first slot
        logic cur_last;    // the cursor is at the last slot of the combination
        logic out_free;    // the output register can take a result
    } t_sts;

endpackage

// ----- hw/rtl/kce_ctrl.sv -----
module kce_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_operation,
    input  kce_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output kce_pkg::t_cmd o_cmd
);
    import kce_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT,
        S_EXH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;
    logic   accept;

    assign accept     = i_in_valid && r_in_ready;
    assign o_in_ready = r_in_ready;

    // Next state and the commands for this cycle.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_LOAD) begin
                        o_cmd.insert  = 1'b1;
                        o_cmd.restart = 1'b1;
                    end else if (i_sts.k_bad) begin
                        n_state = S_EXH;
                    end else if (!i_sts.started) begin
                        o_cmd.init_slots = 1'b1;
                        n_state          = S_EMIT;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                priority if (i_sts.can_adv) begin
                    o_cmd.advance = 1'b1;
                    n_state       = S_EMIT;
                end else if (i_sts.cur_zero) begin
                    o_cmd.set_done = 1'b1;
                    n_state        = S_EXH;
                end else begin
                    o_cmd.cur_dec = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_elem = 1'b1;
                    if (i_sts.cur_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EXH: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_exh = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; ready is high exactly in the idle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == S_IDLE);
        end
    end

endmodule

// ----- hw/rtl/kce_datapath.sv -----
module kce_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kce_pkg::K_W-1:0]     i_cfg_wdata,
    input  logic [kce_pkg::VAL_W-1:0]   i_value,
    input  logic                        i_out_ready,
    input  kce_pkg::t_cmd               i_cmd,
    output kce_pkg::t_sts               o_sts,
    output logic                        o_out_valid,
    output logic [kce_pkg::VAL_W-1:0]   o_element,
    output logic                        o_last_of_run,
    output logic                        o_exhausted
);
    import kce_pkg::*;

    t_val            r_store [MAX_ELEMENTS];
    t_val            n_store [MAX_ELEMENTS];
    t_idx            r_slot  [MAX_ELEMENTS];
    t_idx            n_slot  [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] gt;
    t_cnt            r_count;
    logic [K_W-1:0]  r_k;
    logic            r_started;
    logic            r_done;
    t_idx            r_cur;
    logic            r_out_valid;
    t_val            r_element;
    logic            r_last;
    logic            r_exh;
    t_idx            cur_slot;
    logic [CMP_W-1:0] k_ext;
    logic [CMP_W-1:0] cnt_ext;
    logic [CMP_W-1:0] cur_ext;
    logic [CMP_W-1:0] adv_limit;
    logic            out_free;
    logic            store_full;

    assign cur_slot   = r_slot[r_cur];
    assign k_ext      = CMP_W'(r_k);
    assign cnt_ext    = CMP_W'(r_count);
    assign cur_ext    = CMP_W'(r_cur);
    assign adv_limit  = cnt_ext - k_ext + cur_ext;
    assign out_free   = !r_out_valid || i_out_ready;
    assign store_full = (r_count == t_cnt'(MAX_ELEMENTS));

    // Status for the controller.
    always_comb begin
        o_sts.k_bad    = (r_k == '0) || (k_ext > cnt_ext)
                         || (k_ext > CMP_W'(RESULT_LIMIT)) || r_done;
        o_sts.started  = r_started;
        o_sts.can_adv  = (CMP_W'(cur_slot) < adv_limit);
        o_sts.cur_zero = (r_cur == '0);
        o_sts.cur_last = (cur_ext == k_ext - CMP_W'(1));
        o_sts.out_free = out_free;
    end

    // Sorted insertion: every stored entry above the value moves up one place.
    always_comb begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            gt[i] = (t_cnt'(i) < r_count) && (r_store[i] > i_value);
        end
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
            n_store[i] = r_store[i];
        end
        if (gt[0] || (r_count == '0)) begin
            n_store[0] = i_value;
        end
        for (int i = 1; i < MAX_ELEMENTS; i++) begin
            if (gt[i-1]) begin
                n_store[i] = r_store[i-1];
            end else if (gt[i] || (t_cnt'(i) == r_count)) begin
                n_store[i] = i_value;
            end
        end
    end

    // Index slots: first combination, or bump at the cursor and refill after it.
    always_comb begin
        for (int j = 0; j < MAX_ELEMENTS; j++) begin
            n_slot[j] = r_slot[j];
            if (i_cmd.init_slots) begin
                n_slot[j] = t_idx'(j);
            end else if (i_cmd.advance && (t_idx'(j) >= r_cur)) begin
                n_slot[j] = cur_slot + t_idx'(j) - r_cur + t_idx'(1);
            end
        end
    end

    // Store and slot arrays.
    always_ff @(posedge i_clk) begin
        if (i_cmd.insert && !store_full) begin
            r_store <= n_store;
        end
        if (i_cmd.init_slots || i_cmd.advance) begin
            r_slot <= n_slot;
        end
    end

    // Enumeration control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_k       <= K_W'(1);
            r_started <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            if (i_cmd.insert && !store_full) begin
                r_count <= r_count + t_cnt'(1);
            end
            if (i_cfg_we) begin
                r_k <= i_cfg_wdata;
            end
            if (i_cmd.restart || i_cfg_we) begin
                r_started <= 1'b0;
                r_done    <= 1'b0;
            end else begin
                if (i_cmd.init_slots) begin
                    r_started <= 1'b1;
                end
                if (i_cmd.set_done) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Cursor over the slots, shared by the scan and the emission.
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.init_slots || i_cmd.advance) begin
            r_cur <= '0;
        end else if (i_cmd.scan_start) begin
            r_cur <= t_idx'(r_k - K_W'(1));
        end else if (i_cmd.cur_dec) begin
            r_cur <= r_cur - t_idx'(1);
        end else if (i_cmd.emit_elem) begin
            r_cur <= r_cur + t_idx'(1);
        end else begin
            r_cur <= r_cur;
        end
    end

    // Output register: loaded when free, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_elem || i_cmd.emit_exh) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_elem) begin
            r_element <= r_store[cur_slot];
            r_last    <= o_sts.cur_last;
            r_exh     <= 1'b0;
        end else if (i_cmd.emit_exh) begin
            r_element <= '0;
            r_last    <= 1'b1;
            r_exh     <= 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_element     = r_element;
    assign o_last_of_run = r_last;
    assign o_exhausted   = r_exh;

endmodule

// ----- hw/rtl/k_combination_enumerator.sv -----
// K-combination enumerator over a small sorted store.
//
// Input channel (i_in_valid / o_in_ready): a request with i_operation load
// inserts i_value into the sorted store and gives no result; a full store
// drops the value. Either way the enumeration starts over.
// A next request gives the next K-element combination in lexicographic order,
// one element per result, ascending, with o_last_of_run on the final one; when
// none is left, or K is zero or above the stored count, one result with
// o_exhausted and o_last_of_run set and element 0 is given instead.
// Output channel (o_out_valid / i_out_ready) is driven from a result register.
// Timing: for the first combination the elements are emitted straight away;
// for later ones a scan first moves the cursor left one slot per cycle to the
// rightmost index that can advance. The K elements then leave one per cycle
// while the receiver takes them; the block accepts no new request until the
// last result of the previous one is in the result register.
// K is to be written through i_cfg_we / i_cfg_wdata only while idle; the block
// does not enforce this. A write also restarts the enumeration. A synchronous
// low on i_rst_n empties the store, sets K to one and drops any pending result.
// A stalled receiver simply holds the block; no result is lost.
module k_combination_enumerator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [kce_pkg::K_W-1:0]     i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [kce_pkg::VAL_W-1:0]   i_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [kce_pkg::VAL_W-1:0]   o_element,
    output logic                        o_last_of_run,
    output logic                        o_exhausted
);
    import kce_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    kce_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_cmd       (cmd)
    );

    // Store, index slots and result register.
    kce_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_value       (i_value),
        .i_out_ready   (i_out_ready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (o_out_valid),
        .o_element     (o_element),
        .o_last_of_run (o_last_of_run),
        .o_exhausted   (o_exhausted)
    );

    // An exhausted result always closes its run and carries element zero.
    a_exh_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_exhausted) |-> (o_last_of_run && (o_element == '0)))
        else $error("exhausted result with wrong fields");

    // The controller never loads a result over one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit_elem || cmd.emit_exh) |-> sts.out_free)
        else $error("result register overwritten");

    // A next request always keeps the input side busy in the following cycle.
    a_next_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_operation == OP_NEXT)) |=> !o_in_ready)
        else $error("next request did not hold off the input");

endmodule
